FILE: hw/rtl/doubly_linked_list_engine_macros.svh
// Assertion macros for the doubly linked list engine.
`ifndef DOUBLY_LINKED_LIST_ENGINE_MACROS_SVH
`define DOUBLY_LINKED_LIST_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define DLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DLE_ASSERT_NEVER(lbl, cond, msg) \
    `DLE_ASSERT(lbl, !(cond), msg)
`else
`define DLE_ASSERT(lbl, prop, msg)
`define DLE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hw/rtl/dle_pkg.sv
// Package: command and result word types and codes for the list engine.
`default_nettype none
package dle_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 7;
    localparam int LEN_W = 7;

    localparam logic [3:0] OP_INS_HEAD = 4'd0;
    localparam logic [3:0] OP_INS_TAIL = 4'd1;
    localparam logic [3:0] OP_INS_AT   = 4'd2;
    localparam logic [3:0] OP_DEL_HEAD = 4'd3;
    localparam logic [3:0] OP_DEL_TAIL = 4'd4;
    localparam logic [3:0] OP_DEL_AT   = 4'd5;
    localparam logic [3:0] OP_DUMP_FWD = 4'd6;
    localparam logic [3:0] OP_DUMP_REV = 4'd7;
    localparam logic [3:0] OP_CLEAR    = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [3:0]              op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] item_value;
        logic [1:0]              status;
        logic                    last;
        logic [LEN_W-1:0]        length;
    } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dle_pool.sv
// Node pool: value, forward link and backward link memories, one read address.
`default_nettype none
module dle_pool
    import dle_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IW    = 6,
    parameter int VW    = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          clear,
    input  wire logic          rd_en,
    input  wire logic [IW-1:0] rd_addr,
    output logic [VW-1:0]      val_rd,
    output logic [IW-1:0]      fwd_rd,
    output logic [IW-1:0]      bwd_rd,
    input  wire logic          val_we,
    input  wire logic [IW-1:0] val_waddr,
    input  wire logic [VW-1:0] val_wdata,
    input  wire logic          fwd_we,
    input  wire logic [IW-1:0] fwd_waddr,
    input  wire logic [IW-1:0] fwd_wdata,
    input  wire logic          bwd_we,
    input  wire logic [IW-1:0] bwd_waddr,
    input  wire logic [IW-1:0] bwd_wdata
);

    logic [VW-1:0]    val_mem [DEPTH];
    logic [IW-1:0]    fwd_mem [DEPTH];
    logic [IW-1:0]    bwd_mem [DEPTH];
    logic [DEPTH-1:0] fwd_vld_reg;
    logic             vld_q_reg;
    logic [IW-1:0]    addr_q_reg;
    logic [IW-1:0]    fwd_q_reg;

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (fwd_we)
        begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        if (bwd_we)
        begin
            bwd_mem[bwd_waddr] <= bwd_wdata;
        end
        if (rd_en)
        begin
            val_rd     <= val_mem[rd_addr];
            fwd_q_reg  <= fwd_mem[rd_addr];
            bwd_rd     <= bwd_mem[rd_addr];
            addr_q_reg <= rd_addr;
        end
    end

    // unwritten forward link reads as the reset chain i+1 (the last entry links to 0)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vld_reg <= '0;
            vld_q_reg   <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                vld_q_reg <= fwd_vld_reg[rd_addr] && !(fwd_we && fwd_waddr == rd_addr) ?
                             1'b1 : fwd_vld_reg[rd_addr];
            end
            if (clear)
            begin
                fwd_vld_reg <= '0;
            end
            else if (fwd_we)
            begin
                fwd_vld_reg[fwd_waddr] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (vld_q_reg)
        begin
            fwd_rd = fwd_q_reg;
        end
        else if (addr_q_reg == IW'(DEPTH - 1))
        begin
            fwd_rd = '0;
        end
        else
        begin
            fwd_rd = addr_q_reg + IW'(1);
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/doubly_linked_list_engine.sv
// Top level: doubly linked list engine, command sequencer over the node pool.
//
//   channel  | handshake      | word
//   ---------+----------------+---------------------------------------
//   command  | start / busy   | cmd    (op, value, position)
//   result   | done strobe    | result (item_value, status, last, length)
//
// Errors, clear and unknown ops: result in the cycle after start.
// Head/tail insert finishes in S_TAKE; head/tail delete in S_WALK, S_WSTEP, S_DGIVE.
// Positional ops walk node by node. Dump: one link memory read per step sets the pace.
// Reset leaves an empty list; no clearing pass. Results cannot be stalled.
`default_nettype none
module doubly_linked_list_engine
    import dle_pkg::*;
#(
    parameter int POOL_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    output logic      done,
    output result_t   result
);

    `include "doubly_linked_list_engine_macros.svh"

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_TAKE, S_WALK, S_WSTEP, S_LINK1, S_LINK2, S_DGIVE, S_DUMPRD, S_DUMPEM
    } state_t;

    state_t           state_reg, state_next;
    logic [3:0]       op_reg, op_next;
    logic [CW-1:0]    p_reg, p_next;
    logic [CW-1:0]    steps_reg, steps_next;
    logic [IW-1:0]    cur_reg, cur_next;
    logic [IW-1:0]    node_reg, node_next;
    logic [IW-1:0]    nx_reg, nx_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic [IW-1:0]    free_reg, free_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             done_next;
    result_t          res_next;

    logic                   clear;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] val_rd;
    logic [IW-1:0]          fwd_rd;
    logic [IW-1:0]          bwd_rd;
    logic                   val_we;
    logic [IW-1:0]          val_waddr;
    logic [VALUE_WIDTH-1:0] val_wdata;
    logic                   fwd_we;
    logic [IW-1:0]          fwd_waddr;
    logic [IW-1:0]          fwd_wdata;
    logic                   bwd_we;
    logic [IW-1:0]          bwd_waddr;
    logic [IW-1:0]          bwd_wdata;

    dle_pool #(
        .DEPTH (POOL_DEPTH),
        .IW    (IW),
        .VW    (VALUE_WIDTH)
    ) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .val_rd    (val_rd),
        .fwd_rd    (fwd_rd),
        .bwd_rd    (bwd_rd),
        .val_we    (val_we),
        .val_waddr (val_waddr),
        .val_wdata (val_wdata),
        .fwd_we    (fwd_we),
        .fwd_waddr (fwd_waddr),
        .fwd_wdata (fwd_wdata),
        .bwd_we    (bwd_we),
        .bwd_waddr (bwd_waddr),
        .bwd_wdata (bwd_wdata)
    );

    function automatic result_t mk_res(logic [VALUE_WIDTH-1:0] v, logic [1:0] st,
                                       logic lst, logic [CW-1:0] len);
        result_t r;
        r.item_value = VAL_W'(v);
        r.status     = st;
        r.last       = lst;
        r.length     = LEN_W'(len);
        return r;
    endfunction

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        logic [PW-1:0] pos_w;
        logic [PW-1:0] cnt_w;
        logic [CW-1:0] p_sel;
        logic          is_ins;
        logic          is_del;
        pos_w  = PW'(cmd.position);
        cnt_w  = PW'(count_reg);
        p_sel  = '0;
        is_ins = (cmd.op == OP_INS_HEAD) || (cmd.op == OP_INS_TAIL) || (cmd.op == OP_INS_AT);
        is_del = (cmd.op == OP_DEL_HEAD) || (cmd.op == OP_DEL_TAIL) || (cmd.op == OP_DEL_AT);

        state_next = state_reg;
        op_next    = op_reg;
        p_next     = p_reg;
        steps_next = steps_reg;
        cur_next   = cur_reg;
        node_next  = node_reg;
        nx_next    = nx_reg;
        val_next   = val_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        res_next   = result;
        clear      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = cur_reg;
        val_we     = 1'b0;
        val_waddr  = node_reg;
        val_wdata  = val_reg;
        fwd_we     = 1'b0;
        fwd_waddr  = node_reg;
        fwd_wdata  = head_reg;
        bwd_we     = 1'b0;
        bwd_waddr  = head_reg;
        bwd_wdata  = node_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd.op;
                    val_next = VALUE_WIDTH'($unsigned(cmd.value));
                    if (is_ins)
                    begin
                        if (count_reg == CW'(POOL_DEPTH))
                        begin
                            done_next = 1'b1;
                            res_next  = mk_res('0, ST_FULL, 1'b1, count_reg);
                        end
                        else if (cmd.op == OP_INS_AT &&
                                 (pos_w == '0 || pos_w > cnt_w + PW'(1)))
                        begin
                            done_next = 1'b1;
                            res_next  = mk_res('0, ST_RANGE, 1'b1, count_reg);
                        end
                        else
                        begin
                            if (cmd.op == OP_INS_HEAD)
                            begin
                                p_next = CW'(1);
                            end
                            else if (cmd.op == OP_INS_TAIL)
                            begin
                                p_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                p_next = CW'(cmd.position);
                            end
                            rd_en      = 1'b1;
                            rd_addr    = free_reg;
                            node_next  = free_reg;
                            state_next = S_TAKE;
                        end
                    end
                    else if (is_del)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next = 1'b1;
                            res_next  = mk_res('0, ST_EMPTY, 1'b1, count_reg);
                        end
                        else if (cmd.op == OP_DEL_AT && (pos_w == '0 || pos_w > cnt_w))
                        begin
                            done_next = 1'b1;
                            res_next  = mk_res('0, ST_RANGE, 1'b1, count_reg);
                        end
                        else
                        begin
                            if (cmd.op == OP_DEL_HEAD)
                            begin
                                p_sel = CW'(1);
                            end
                            else if (cmd.op == OP_DEL_TAIL)
                            begin
                                p_sel = count_reg;
                            end
                            else
                            begin
                                p_sel = CW'(cmd.position);
                            end
                            p_next     = p_sel;
                            steps_next = '0;
                            state_next = S_WALK;
                            if (count_reg == CW'(1) || p_sel == CW'(1))
                            begin
                                cur_next = head_reg;
                            end
                            else if (p_sel == count_reg)
                            begin
                                cur_next = tail_reg;
                            end
                            else
                            begin
                                cur_next   = head_reg;
                                steps_next = p_sel - CW'(1);
                            end
                        end
                    end
                    else if (cmd.op == OP_DUMP_FWD || cmd.op == OP_DUMP_REV)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next = 1'b1;
                            res_next  = mk_res('0, ST_EMPTY, 1'b1, count_reg);
                        end
                        else
                        begin
                            cur_next   = (cmd.op == OP_DUMP_FWD) ? head_reg : tail_reg;
                            steps_next = count_reg - CW'(1);
                            state_next = S_DUMPRD;
                        end
                    end
                    else if (cmd.op == OP_CLEAR)
                    begin
                        clear      = 1'b1;
                        head_next  = '0;
                        tail_next  = '0;
                        free_next  = '0;
                        count_next = '0;
                        done_next  = 1'b1;
                        res_next   = mk_res('0, ST_OK, 1'b1, '0);
                    end
                    else
                    begin
                        done_next = 1'b1;
                        res_next  = mk_res('0, ST_OK, 1'b1, count_reg);
                    end
                end
            end

            S_TAKE:
            begin
                free_next = fwd_rd;
                val_we    = 1'b1;
                if (count_reg == '0 || p_reg == CW'(1) || p_reg == count_reg + CW'(1))
                begin
                    if (count_reg == '0)
                    begin
                        head_next = node_reg;
                        tail_next = node_reg;
                    end
                    else if (p_reg == CW'(1))
                    begin
                        fwd_we    = 1'b1;
                        fwd_waddr = node_reg;
                        fwd_wdata = head_reg;
                        bwd_we    = 1'b1;
                        bwd_waddr = head_reg;
                        bwd_wdata = node_reg;
                        head_next = node_reg;
                    end
                    else
                    begin
                        bwd_we    = 1'b1;
                        bwd_waddr = node_reg;
                        bwd_wdata = tail_reg;
                        fwd_we    = 1'b1;
                        fwd_waddr = tail_reg;
                        fwd_wdata = node_reg;
                        tail_next = node_reg;
                    end
                    count_next = count_reg + CW'(1);
                    done_next  = 1'b1;
                    res_next   = mk_res('0, ST_OK, 1'b1, count_reg + CW'(1));
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = head_reg;
                    steps_next = p_reg - CW'(2);
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                rd_en      = 1'b1;
                rd_addr    = cur_reg;
                state_next = S_WSTEP;
            end

            S_WSTEP:
            begin
                if (steps_reg != '0)
                begin
                    cur_next   = fwd_rd;
                    steps_next = steps_reg - CW'(1);
                    state_next = S_WALK;
                end
                else if (op_reg == OP_INS_HEAD || op_reg == OP_INS_TAIL || op_reg == OP_INS_AT)
                begin
                    nx_next    = fwd_rd;
                    state_next = S_LINK1;
                end
                else
                begin
                    node_next  = cur_reg;
                    val_next   = val_rd;
                    state_next = S_DGIVE;
                    if (count_reg == CW'(1))
                    begin
                        head_next = head_reg;
                    end
                    else if (p_reg == CW'(1))
                    begin
                        head_next = fwd_rd;
                    end
                    else if (p_reg == count_reg)
                    begin
                        tail_next = bwd_rd;
                    end
                    else
                    begin
                        fwd_we    = 1'b1;
                        fwd_waddr = bwd_rd;
                        fwd_wdata = fwd_rd;
                        bwd_we    = 1'b1;
                        bwd_waddr = fwd_rd;
                        bwd_wdata = bwd_rd;
                    end
                end
            end

            S_LINK1:
            begin
                fwd_we     = 1'b1;
                fwd_waddr  = node_reg;
                fwd_wdata  = nx_reg;
                bwd_we     = 1'b1;
                bwd_waddr  = node_reg;
                bwd_wdata  = cur_reg;
                state_next = S_LINK2;
            end

            S_LINK2:
            begin
                bwd_we     = 1'b1;
                bwd_waddr  = nx_reg;
                bwd_wdata  = node_reg;
                fwd_we     = 1'b1;
                fwd_waddr  = cur_reg;
                fwd_wdata  = node_reg;
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
                res_next   = mk_res('0, ST_OK, 1'b1, count_reg + CW'(1));
                state_next = S_IDLE;
            end

            S_DGIVE:
            begin
                fwd_we     = 1'b1;
                fwd_waddr  = node_reg;
                fwd_wdata  = free_reg;
                free_next  = node_reg;
                count_next = count_reg - CW'(1);
                done_next  = 1'b1;
                res_next   = mk_res(val_reg, ST_OK, 1'b1, count_reg - CW'(1));
                state_next = S_IDLE;
            end

            S_DUMPRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = cur_reg;
                state_next = S_DUMPEM;
            end

            S_DUMPEM:
            begin
                done_next = 1'b1;
                res_next  = mk_res(val_rd, ST_OK, steps_reg == '0, count_reg);
                if (steps_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = (op_reg == OP_DUMP_FWD) ? fwd_rd : bwd_rd;
                    steps_next = steps_reg - CW'(1);
                    state_next = S_DUMPRD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            free_reg  <= '0;
            count_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            done      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        p_reg     <= p_next;
        steps_reg <= steps_next;
        cur_reg   <= cur_next;
        node_reg  <= node_next;
        nx_reg    <= nx_next;
        val_reg   <= val_next;
        result    <= res_next;
    end

    `DLE_ASSERT_NEVER(a_count_bound, count_reg > CW'(POOL_DEPTH), "list count above pool depth")
    `DLE_ASSERT_NEVER(a_done_idle, done && result.last && busy, "final word while still busy")
    `DLE_ASSERT(a_accept_progress, start && !busy |=> busy || done, "accepted word lost")

endmodule
`default_nettype wire
